/* hdl/kmrc_pkg.sv */
`default_nettype none
package kmrc_pkg;
  localparam int unsigned ValW = 32;
  localparam int unsigned LaneW = 5;
  localparam int unsigned CntW = 6;

  typedef enum logic [1:0] {
    KIND_REFILL = 2'd0,
    KIND_RUN    = 2'd1,
    KIND_DONE   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_LOAD  = 2'd0,
    PH_MERGE = 2'd1,
    PH_DONE  = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    H_IDLE, H_UP_RD, H_UP_CMP, H_POP_RD, H_POP_WR,
    H_DN_RDL, H_DN_RDR, H_DN_CMP, H_DN_WR
  } hstate_e;

  typedef enum logic [2:0] {
    C_IDLE, C_WAIT, C_RUN, C_DONE_OUT, C_REFILL
  } cstate_e;

  typedef struct packed {
    logic [ValW-1:0]  value;
    logic [LaneW-1:0] lane;
  } entry_t;

  typedef struct packed {
    kind_e            kind;
    logic [LaneW-1:0] lane;
    logic [ValW-1:0]  value;
    logic [ValW-1:0]  count;
    logic             last;
  } result_t;

  function automatic logic entry_less(entry_t a, entry_t b);
    if (a.value != b.value) begin
      return a.value < b.value;
    end
    return a.lane < b.lane;
  endfunction
endpackage
`default_nettype wire

/* hdl/kmrc_heap.sv */
`default_nettype none
// min-heap in one synchronous ram, one ram read per cycle; insert sifts up (read,
// compare per level), pop sifts down (read left, read right, compare per level)
module kmrc_heap #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5,
  parameter int unsigned SizeW = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              ins_i,
  input  wire logic              pop_i,
  input  wire kmrc_pkg::entry_t  ins_entry_i,
  output logic                   busy_o,
  output logic [SizeW-1:0]       size_o,
  output kmrc_pkg::entry_t       top_o
);
  import kmrc_pkg::*;

  entry_t mem [Depth];
  entry_t rdata_q;
  logic [AddrW-1:0] raddr;
  logic rd_en;
  logic we;
  logic [AddrW-1:0] waddr;
  entry_t wdata;

  hstate_e st_q, st_d;
  logic [SizeW-1:0] size_q, size_d;
  logic [SizeW-1:0] idx_q, idx_d;    // hole position
  entry_t cur_q, cur_d;              // entry being sifted
  entry_t top_q, top_d;
  entry_t lch_q, lch_d;
  logic pop_pend_q, pop_pend_d;
  logic [SizeW:0] lidx, ridx;
  logic [SizeW-1:0] par;
  entry_t best;
  logic [SizeW-1:0] best_idx;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= H_IDLE;
      size_q <= '0;
      pop_pend_q <= 1'b0;
    end else begin
      st_q <= st_d;
      size_q <= size_d;
      pop_pend_q <= pop_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cur_q <= cur_d;
    top_q <= top_d;
    lch_q <= lch_d;
  end

  assign par  = (idx_q - SizeW'(1)) >> 1;
  assign lidx = {idx_q, 1'b1};
  assign ridx = lidx + (SizeW+1)'(1);

  always_comb begin
    if (ridx < {1'b0, size_q} && entry_less(rdata_q, lch_q)) begin
      best = rdata_q;
      best_idx = ridx[SizeW-1:0];
    end else begin
      best = lch_q;
      best_idx = lidx[SizeW-1:0];
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    size_d = size_q;
    idx_d = idx_q;
    cur_d = cur_q;
    top_d = top_q;
    lch_d = lch_q;
    pop_pend_d = pop_pend_q;
    case (st_q)
      H_IDLE: begin
        if (ins_i && size_q < SizeW'(Depth)) begin
          pop_pend_d = pop_i;
          cur_d = ins_entry_i;
          idx_d = size_q;
          size_d = size_q + SizeW'(1);
          st_d = H_UP_RD;
        end else if (pop_i) begin
          st_d = H_POP_RD;
        end
      end
      H_UP_RD: begin
        if (idx_q == '0) begin
          top_d = cur_q;
          st_d = pop_pend_q ? H_POP_RD : H_IDLE;
          pop_pend_d = 1'b0;
        end else begin
          st_d = H_UP_CMP;
        end
      end
      H_UP_CMP: begin
        if (entry_less(cur_q, rdata_q)) begin
          idx_d = par;
          st_d = H_UP_RD;
        end else begin
          st_d = pop_pend_q ? H_POP_RD : H_IDLE;
          pop_pend_d = 1'b0;
        end
      end
      H_POP_RD: begin
        size_d = size_q - SizeW'(1);
        st_d = H_POP_WR;
      end
      H_POP_WR: begin
        cur_d = rdata_q;
        idx_d = '0;
        if (size_q == '0) begin
          st_d = H_IDLE;
        end else begin
          st_d = H_DN_RDL;
        end
      end
      H_DN_RDL: begin
        if (lidx < {1'b0, size_q}) begin
          st_d = H_DN_RDR;
        end else begin
          st_d = H_DN_WR;
        end
      end
      H_DN_RDR: begin
        lch_d = rdata_q;
        st_d = H_DN_CMP;
      end
      H_DN_CMP: begin
        if (entry_less(best, cur_q)) begin
          if (idx_q == '0) begin
            top_d = best;
          end
          idx_d = best_idx;
          st_d = H_DN_RDL;
        end else begin
          st_d = H_DN_WR;
        end
      end
      H_DN_WR: begin
        if (idx_q == '0) begin
          top_d = cur_q;
        end
        st_d = H_IDLE;
      end
      default: st_d = H_IDLE;
    endcase
  end

  // ram control
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = cur_q;
    rd_en = 1'b0;
    raddr = '0;
    case (st_q)
      H_UP_RD: begin
        if (idx_q == '0) begin
          we = 1'b1;
          waddr = AddrW'(idx_q);
          wdata = cur_q;
        end else begin
          rd_en = 1'b1;
          raddr = AddrW'(par);
        end
      end
      H_UP_CMP: begin
        we = 1'b1;
        waddr = AddrW'(idx_q);
        wdata = entry_less(cur_q, rdata_q) ? rdata_q : cur_q;
      end
      H_POP_RD: begin
        // fetch the last entry to move to the root
        rd_en = 1'b1;
        raddr = AddrW'(size_q - SizeW'(1));
      end
      H_DN_RDL: begin
        if (lidx < {1'b0, size_q}) begin
          rd_en = 1'b1;
          raddr = AddrW'(lidx);
        end
      end
      H_DN_RDR: begin
        rd_en = 1'b1;
        raddr = AddrW'(ridx);
      end
      H_DN_CMP: begin
        if (entry_less(best, cur_q)) begin
          we = 1'b1;
          waddr = AddrW'(idx_q);
          wdata = best;
        end
      end
      H_DN_WR: begin
        we = 1'b1;
        waddr = AddrW'(idx_q);
        wdata = cur_q;
      end
      default: we = 1'b0;
    endcase
  end

  assign busy_o = (st_q != H_IDLE);
  assign size_o = size_q;
  assign top_o  = top_q;
endmodule
`default_nettype wire

/* hdl/kway_merge_run_counter_core.sv */
// a merging request waits for any insert sift-up in the heap ram, then pops;
// a run record may be offered during the pop sift-down, a refill after it
// one request at a time: input is held off while an insert sifts and until a
// merging request's results are taken, so output stalls hold off input too
// reset: asynchronous active low, phase to loading, counters and run cleared;
// heap ram contents are not cleared, only entries below the size are read
`default_nettype none
module kway_merge_run_counter_core #(
  parameter int unsigned LANES = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // lane[4:0], in_value[36:5], zero pad
  input  wire logic        s_axis_tuser,   // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // refill_lane[4:0], out_value[36:5],
                                           // run_count[68:37], zero pad
  output logic [1:0]       m_axis_tuser,   // result_kind
  output logic             m_axis_tlast
);
  import kmrc_pkg::*;

  localparam int unsigned AddrW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned SizeW = $clog2(LANES + 1);
  // the lane count register cannot exceed 63
  localparam int unsigned EffMax = (LANES > 63) ? 63 : LANES;

  logic [5:0] lane_cnt_q;
  phase_e phase_q, phase_d;
  logic [5:0] answered_q, answered_d;
  logic [ValW-1:0] run_val_q, run_val_d, run_cnt_q, run_cnt_d;
  cstate_e cs_q, cs_d;
  logic [LaneW-1:0] pop_lane_q, pop_lane_d;
  logic flush_q, flush_d;
  logic [ValW-1:0] rec_val_q, rec_val_d, rec_cnt_q, rec_cnt_d;

  logic h_ins, h_pop, h_busy;
  logic [SizeW-1:0] h_size;
  entry_t h_top, ins_e;
  logic [6:0] eff;
  logic s_acc, m_acc;
  logic do_merge;

  kmrc_heap #(.Depth(LANES), .AddrW(AddrW), .SizeW(SizeW)) u_heap (
    .clk_i, .rst_ni,
    .ins_i(h_ins), .pop_i(h_pop), .ins_entry_i(ins_e),
    .busy_o(h_busy), .size_o(h_size), .top_o(h_top)
  );

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;
  // hold off while a loading insert is still sifting
  assign s_axis_tready = (cs_q == C_IDLE) && !h_busy;
  assign ins_e.value = s_axis_tdata[36:5];
  assign ins_e.lane  = s_axis_tdata[4:0];

  always_comb begin
    eff = (lane_cnt_q == '0) ? 7'd1 : {1'b0, lane_cnt_q};
    if (eff > 7'(EffMax)) begin
      eff = 7'(EffMax);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_cnt_q <= 6'd32;
      phase_q <= PH_LOAD;
      answered_q <= '0;
      run_val_q <= '0;
      run_cnt_q <= '0;
      cs_q <= C_IDLE;
      flush_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lane_cnt_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      answered_q <= answered_d;
      run_val_q <= run_val_d;
      run_cnt_q <= run_cnt_d;
      cs_q <= cs_d;
      flush_q <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pop_lane_q <= pop_lane_d;
    rec_val_q <= rec_val_d;
    rec_cnt_q <= rec_cnt_d;
  end

  // next state and datapath
  always_comb begin
    cs_d = cs_q;
    phase_d = phase_q;
    answered_d = answered_q;
    run_val_d = run_val_q;
    run_cnt_d = run_cnt_q;
    pop_lane_d = pop_lane_q;
    flush_d = flush_q;
    rec_val_d = rec_val_q;
    rec_cnt_d = rec_cnt_q;
    h_ins = 1'b0;
    h_pop = 1'b0;
    do_merge = 1'b0;
    case (cs_q)
      C_IDLE: begin
        if (s_acc && phase_q != PH_DONE) begin
          h_ins = !s_axis_tuser;
          if (phase_q == PH_LOAD) begin
            if (answered_q != 6'd63) begin
              answered_d = answered_q + 6'd1;
            end
            do_merge = ({1'b0, answered_d} >= eff);
            if (do_merge) begin
              phase_d = PH_MERGE;
            end
          end else begin
            do_merge = 1'b1;
          end
          if (do_merge) begin
            cs_d = C_WAIT;
          end
        end
      end
      C_WAIT: begin
        if (!h_busy) begin
          if (h_size == '0) begin
            flush_d = (run_cnt_q != '0);
            rec_val_d = run_val_q;
            rec_cnt_d = run_cnt_q;
            run_val_d = '0;
            run_cnt_d = '0;
            phase_d = PH_DONE;
            cs_d = C_DONE_OUT;
          end else begin
            h_pop = 1'b1;
            pop_lane_d = h_top.lane;
            if (h_top.value == run_val_q) begin
              flush_d = 1'b0;
              if (run_cnt_q != '1) begin
                run_cnt_d = run_cnt_q + ValW'(1);
              end
            end else begin
              flush_d = (run_cnt_q != '0);
              rec_val_d = run_val_q;
              rec_cnt_d = run_cnt_q;
              run_val_d = h_top.value;
              run_cnt_d = ValW'(1);
            end
            cs_d = C_REFILL;
          end
        end
      end
      C_DONE_OUT, C_REFILL: begin
        if (m_acc) begin
          if (flush_q) begin
            flush_d = 1'b0;
          end else begin
            cs_d = C_IDLE;
          end
        end
      end
      default: cs_d = C_IDLE;
    endcase
  end

  // output drive
  always_comb begin
    m_axis_tvalid = 1'b0;
    m_axis_tuser = KIND_REFILL;
    m_axis_tlast = 1'b0;
    m_axis_tdata = '0;
    case (cs_q)
      C_DONE_OUT, C_REFILL: begin
        m_axis_tvalid = !(cs_q == C_REFILL && h_busy && !flush_q);
        if (flush_q) begin
          m_axis_tuser = KIND_RUN;
          m_axis_tdata[36:5] = rec_val_q;
          m_axis_tdata[68:37] = rec_cnt_q;
        end else if (cs_q == C_DONE_OUT) begin
          m_axis_tuser = KIND_DONE;
          m_axis_tlast = 1'b1;
        end else begin
          m_axis_tuser = KIND_REFILL;
          m_axis_tdata[4:0] = pop_lane_q;
          m_axis_tlast = 1'b1;
        end
      end
      default: m_axis_tvalid = 1'b0;
    endcase
  end
endmodule
`default_nettype wire

/* hdl/kmrc_checker.sv */
`default_nettype none
module kmrc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);
  import kmrc_pkg::*;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_REFILL || m_axis_tuser == KIND_RUN ||
                       m_axis_tuser == KIND_DONE))
    else $error("bad kind");
  a_run_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_RUN) |-> !m_axis_tlast)
    else $error("run record marked last");
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_DONE) |=> !m_axis_tvalid)
    else $error("output after done");
endmodule

bind kway_merge_run_counter_core kmrc_checker u_kmrc_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tlast
);
`default_nettype wire

/* dv/tb_kway_merge_run_counter_core.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_kway_merge_run_counter_core;
  import kmrc_pkg::*;

  localparam int NumLanes = 32;
  localparam int DrainCycles = 150;

  class merge_scoreboard;
    logic [5:0]  lane_cfg;
    logic [36:0] heap_keys [NumLanes];  // {value, lane}, so a plain compare orders them
    int          heap_fill;
    int          answers_seen;
    phase_e      phase;
    logic [31:0] run_value;
    logic [31:0] run_length;
    logic [4:0]  next_lane;
    result_t     expected_results [$];
    int          mismatches;

    function new();
      lane_cfg = 6'd32;
      heap_fill = 0;
      answers_seen = 0;
      phase = PH_LOAD;
      run_value = '0;
      run_length = '0;
      next_lane = '0;
      mismatches = 0;
    endfunction

    function void heap_push(logic [36:0] key);
      int i;
      int p;
      logic [36:0] t;
      if (heap_fill >= NumLanes) return;
      i = heap_fill;
      heap_fill++;
      heap_keys[i] = key;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (heap_keys[i] >= heap_keys[p]) break;
        t = heap_keys[i];
        heap_keys[i] = heap_keys[p];
        heap_keys[p] = t;
        i = p;
      end
    endfunction

    function logic [36:0] heap_pop_min();
      logic [36:0] top;
      logic [36:0] t;
      int i;
      int m;
      int c;
      top = heap_keys[0];
      heap_fill--;
      if (heap_fill == 0) return top;
      heap_keys[0] = heap_keys[heap_fill];
      i = 0;
      forever begin
        m = i;
        c = 2 * i + 1;
        if (c < heap_fill && heap_keys[c] < heap_keys[m]) m = c;
        if (c + 1 < heap_fill && heap_keys[c + 1] < heap_keys[m]) m = c + 1;
        if (m == i) break;
        t = heap_keys[i];
        heap_keys[i] = heap_keys[m];
        heap_keys[m] = t;
        i = m;
      end
      return top;
    endfunction

    function void push_result(kind_e kind, logic [4:0] lane, logic [31:0] value,
                              logic [31:0] count);
      result_t r;
      r.kind = kind;
      r.lane = lane;
      r.value = value;
      r.count = count;
      r.last = 1'b0;
      expected_results.push_back(r);
    endfunction

    function void note_request(logic req_end, logic [4:0] lane, logic [31:0] value);
      int limit;
      logic [36:0] top;
      if (phase == PH_DONE) return;
      if (!req_end) heap_push({value, lane});
      if (phase == PH_LOAD) begin
        limit = (lane_cfg == 0) ? 1 : int'(lane_cfg);
        if (limit > NumLanes) limit = NumLanes;
        if (answers_seen < 63) answers_seen++;
        if (answers_seen < limit) return;
        phase = PH_MERGE;
      end
      if (heap_fill == 0) begin
        // heap drained: flush the open run and finish
        if (run_length != 0) push_result(KIND_RUN, '0, run_value, run_length);
        run_value = '0;
        run_length = '0;
        phase = PH_DONE;
        push_result(KIND_DONE, '0, '0, '0);
      end else begin
        top = heap_pop_min();
        if (top[36:5] == run_value) begin
          if (run_length != 32'hFFFF_FFFF) run_length++;
        end else begin
          if (run_length != 0) push_result(KIND_RUN, '0, run_value, run_length);
          run_value = top[36:5];
          run_length = 1;
        end
        next_lane = top[4:0];
        push_result(KIND_REFILL, top[4:0], '0, '0);
      end
      expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d lane %0d value %0h count %0d last %0b",
                   got.kind, got.lane, got.value, got.count, got.last);
        return;
      end
      want = expected_results.pop_front();
      if (got.kind != want.kind || got.lane != want.lane || got.value != want.value ||
          got.count != want.count || got.last != want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected kind %0d lane %0d value %0h count %0d last %0b,%s",
                   want.kind, want.lane, want.value, want.count, want.last,
                   $sformatf(" got kind %0d lane %0d value %0h count %0d last %0b",
                             got.kind, got.lane, got.value, got.count, got.last));
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [5:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  merge_scoreboard sb;
  logic [31:0] lane_next [NumLanes];
  bit          lane_ended [NumLanes];
  int          lane_sent [NumLanes];
  int          lane_quota [NumLanes];
  int          quiet_mode;
  int          sink_stall;

  kway_merge_run_counter_core #(.LANES(NumLanes)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (quiet_mode != 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sink backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall = 0;
    end else if (sink_stall > 0) begin
      m_axis_tready <= 1'b0;
      sink_stall--;
    end else begin
      m_axis_tready <= 1'b1;
      if (quiet_mode == 0 && $urandom_range(0, 99) < 30)
        sink_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = kind_e'(m_axis_tuser);
      got.lane = m_axis_tdata[4:0];
      got.value = m_axis_tdata[36:5];
      got.count = m_axis_tdata[68:37];
      got.last = m_axis_tlast;
      sb.check_result(got);
    end
  end

  task automatic send_request(input logic req_end, input logic [4:0] lane,
                              input logic [31:0] value, input bit hold);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req_end;
    s_axis_tdata <= {3'b000, value, lane};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(req_end, lane, value);
    if (!hold) s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (sb.expected_results.size() != 0) @(posedge clk_i);
  endtask

  // block must be idle; loading answers give no results so allow the full latency
  task automatic write_lane_count(input logic [5:0] count);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.lane_cfg = count;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] step_value(input logic [31:0] v);
    logic [32:0] s;
    s = {1'b0, v} + (($urandom_range(0, 19) == 0) ? 33'($urandom_range(1000, 1 << 20))
                                                   : 33'($urandom_range(0, 2)));
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  initial begin
    int sent;
    logic [4:0]  lane;
    logic [31:0] value;
    logic        req_end;
    sb = new();
    quiet_mode = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    for (int l = 0; l < NumLanes; l++) begin
      lane_ended[l] = 0;
      lane_sent[l] = 0;
      lane_quota[l] = $urandom_range(3, 9);
      if (l % 4 == 3) lane_next[l] = $urandom();
      else lane_next[l] = $urandom_range(0, 20);
    end
    // equal heads on the two lowest lanes, top-of-range values on the next two
    lane_next[0] = 32'd0;
    lane_next[1] = 32'd0;
    lane_next[2] = 32'hFFFF_FFFF;
    lane_next[3] = 32'hFFFF_FFFE;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_lane_count(6'd63);

    // loading: one first answer per lane, a few lanes empty from the start
    for (int i = 0; i < NumLanes; i++) begin
      lane = 5'(31 - i);
      req_end = (i % 11 == 5);
      if (req_end) lane_ended[lane] = 1;
      value = req_end ? $urandom() : lane_next[lane];
      quiet_mode = (i >= 20 && i < 26);
      send_request(req_end, lane, value, !(i == 9 || i == 19 || i == NumLanes - 1));
      if (!req_end) lane_sent[lane]++;
      if (i == 9) write_lane_count(6'd40);
      if (i == 19) write_lane_count(6'd32);
    end

    // merging: answer each refill request from the requested lane
    sent = NumLanes;
    while (sb.phase != PH_DONE) begin
      wait_drained();
      if (sb.phase == PH_DONE) break;
      if (sent == 70) write_lane_count(6'd0);
      if (sent == 140) write_lane_count(6'd1);
      quiet_mode = ((sent / 20) % 4 == 2);
      lane = sb.next_lane;
      if (sent >= 200 || lane_sent[lane] >= lane_quota[lane]) begin
        req_end = 1'b1;
        value = $urandom();
      end else begin
        req_end = 1'b0;
        lane_next[lane] = step_value(lane_next[lane]);
        value = lane_next[lane];
        lane_sent[lane]++;
      end
      // a little noise: stray lane or out-of-order value
      if ($urandom_range(0, 99) < 4) lane = $urandom_range(0, 31);
      if ($urandom_range(0, 99) < 3) value = $urandom();
      send_request(req_end, lane, value, 1'b0);
      sent++;
    end
    wait_drained();

    // ignored after the merge has finished
    for (int i = 0; i < 3; i++) send_request(1'($urandom_range(0, 1)), 5'($urandom()),
                                             $urandom(), 1'b0);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.expected_results.size() != 0) begin
      sb.mismatches++;
      if (sb.mismatches <= 10)
        $display("%0d expected results never arrived", sb.expected_results.size());
    end
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
